// File: rtl/rssb_pkg.sv
// Shared types and codes for the rotated sprite stamp blitter.
// Holds the input and result word layouts, operation, rotation and register codes.
// No dependencies.
package rssb_pkg;

  typedef struct packed {
    logic              operation;
    logic [5:0]        texel_x;
    logic [5:0]        texel_y;
    logic              texel_opaque;
    logic [7:0]        texel_red;
    logic signed [31:0] stamp_center_x;
    logic signed [31:0] stamp_center_y;
    logic [6:0]        stamp_side;
    logic [7:0]        rotation;
    logic [5:0]        cell_x;
    logic [5:0]        cell_y;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [11:0] cell_index;
    logic [7:0]  material;
  } out_word_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_BACKGROUND = 2'd2;

  localparam logic [7:0] RED_BACKGROUND = 8'hFF;

endpackage

// File: rtl/rssb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rssb_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rotated_sprite_stamp_blit_top.sv
// Rotated sprite stamp blitter: template store, cell test pipeline and APB registers.
// Depends on rssb_pkg and rssb_ram.
//
// Usage:
//   Input (in_valid_i / in_stall_o / in_word_i): one word per cycle unless stalled.
//   A load word writes one texel (opaque bit, red byte) into the template store.
//   A test word carries a stamp centre, size, rotation and one chunk cell, and
//   yields a result word telling whether that cell is written and with what.
//   Every input word yields exactly one result word on out_valid_o / out_stall_i
//   / out_word_o, in order; load words give an all-zero result.
//   Throughput is one word per cycle while out_stall_i is low. Each word goes
//   through five registers to out_valid_o: input register, offset subtract,
//   local offset add, template store read (registered RAM port), result register.
//   A stall from the receiver holds the result register; earlier stages keep
//   accepting words until each holds one, so bubbles are squeezed out first.
//   Reset clears the pipeline valid bits and the registers (origins and
//   background to zero). The template store is not cleared: texels must be
//   loaded before a test reads them. Registers are written over the APB port;
//   the user must write them only while the pipeline is empty (not enforced).
module rotated_sprite_stamp_blit_top
  import rssb_pkg::*;
#(
  parameter int CHUNK_SIDE        = 64,
  parameter int MAX_TEMPLATE_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW    = $clog2(CHUNK_SIDE);
  localparam int OPW   = 19 + CW;
  localparam int DW    = 34 + CW;
  localparam int CIW   = (CW + 7 > 12) ? CW + 7 : 12;
  localparam int IW    = $clog2(MAX_TEMPLATE_SIDE);
  localparam int DEPTH = MAX_TEMPLATE_SIDE * MAX_TEMPLATE_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic signed [17:0] org_x_q, org_y_q;
  logic [7:0]         bg_q;
  logic signed [OPW-1:0] orgx_scaled, orgy_scaled;
  logic               cfg_wr;

  logic v1_q, v2_q, v3_q, v4_q, vout_q;
  logic en1, en2, en3, en4, en_out;
  in_word_t s1_q, s2_q, s3_q;
  logic signed [DW-1:0] dx_q, dy_q, lx_q, ly_q;
  logic                 cand4_q;
  logic [11:0]          cidx4_q;
  out_word_t            out_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      bg_q    <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ORIGIN_X:   org_x_q <= pwdata[17:0];
          REG_ORIGIN_Y:   org_y_q <= pwdata[17:0];
          REG_BACKGROUND: bg_q    <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  assign orgx_scaled = OPW'(org_x_q) * OPW'(CHUNK_SIDE);
  assign orgy_scaled = OPW'(org_y_q) * OPW'(CHUNK_SIDE);

  always_comb begin
    case (paddr[3:2])
      REG_ORIGIN_X:   prdata = {14'd0, org_x_q};
      REG_ORIGIN_Y:   prdata = {14'd0, org_y_q};
      REG_BACKGROUND: prdata = {24'd0, bg_q};
      default:        prdata = '0;
    endcase
  end

  // pipeline advance
  assign en_out     = !vout_q || !out_stall_i;
  assign en4        = !v4_q || en_out;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (en1)    v1_q   <= in_valid_i;
      if (en2)    v2_q   <= v1_q;
      if (en3)    v3_q   <= v2_q;
      if (en4)    v4_q   <= v3_q;
      if (en_out) vout_q <= v4_q;
    end
  end

  // stage 1: offset from centre
  logic signed [OPW-1:0] cellsum_x, cellsum_y;
  logic signed [DW-1:0]  wx_ext, wy_ext, wx, wy, dx_d, dy_d;

  assign cellsum_x = orgx_scaled + $signed(OPW'(s1_q.cell_x));
  assign cellsum_y = orgy_scaled + $signed(OPW'(s1_q.cell_y));
  assign wx_ext    = DW'(cellsum_x);
  assign wy_ext    = DW'(cellsum_y);
  assign wx        = {wx_ext[DW-9:0], 8'h00};
  assign wy        = {wy_ext[DW-9:0], 8'h00};
  assign dx_d      = wx - DW'(s1_q.stamp_center_x);
  assign dy_d      = wy - DW'(s1_q.stamp_center_y);

  // stage 2: local offset
  logic signed [DW-1:0] half, lx_d, ly_d;

  assign half = $signed(DW'({s2_q.stamp_side, 7'd0}));
  assign lx_d = dx_q + half;
  assign ly_d = dy_q + half;

  // stage 3: bounds, rotation, store address
  logic [14:0]          span;
  logic signed [DW-1:0] span_ext;
  logic                 in_box, size_ok, cell_ok, cand_d;
  logic signed [16:0]   lxs, lys, tops, sx, sy;
  rot_e                 rot;
  logic [7:0]           ixw, iyw;
  logic [IW-1:0]        ix, iy;
  logic [AW-1:0]        raddr, waddr;
  logic [CIW-1:0]       cidx_full;
  logic                 ram_we;
  logic [8:0]           ram_rdata;

  function automatic logic [7:0] to_index(input logic signed [16:0] v, input logic [6:0] size);
    logic [7:0] i;
    logic [7:0] lim;
    i   = v[16] ? 8'd0 : v[15:8];
    lim = {1'b0, size} - 8'd1;
    return (i > lim) ? lim : i;
  endfunction

  assign span     = {s3_q.stamp_side, 8'd0};
  assign span_ext = $signed(DW'(span));
  assign in_box   = (lx_q > 0) && (lx_q < span_ext) && (ly_q > 0) && (ly_q < span_ext);
  assign size_ok  = (s3_q.stamp_side != 7'd0)
                 && ({1'b0, s3_q.stamp_side} <= 8'(MAX_TEMPLATE_SIDE));
  assign cell_ok  = (CIW'(s3_q.cell_x) < CIW'(CHUNK_SIDE))
                 && (CIW'(s3_q.cell_y) < CIW'(CHUNK_SIDE));
  assign cand_d   = (s3_q.operation == OP_TEST) && size_ok && cell_ok && in_box;

  assign lxs  = $signed({2'b00, lx_q[14:0]});
  assign lys  = $signed({2'b00, ly_q[14:0]});
  assign tops = $signed({2'b00, span}) - 17'sd256;
  assign rot  = (s3_q.rotation >= 8'd3) ? ROT_270 : rot_e'(s3_q.rotation[1:0]);

  always_comb begin
    case (rot)
      ROT_0: begin
        sx = lxs;
        sy = lys;
      end
      ROT_90: begin
        sx = lys;
        sy = tops - lxs;
      end
      ROT_180: begin
        sx = tops - lxs;
        sy = tops - lys;
      end
      default: begin
        sx = tops - lys;
        sy = lxs;
      end
    endcase
  end

  assign ixw   = to_index(sx, s3_q.stamp_side);
  assign iyw   = to_index(sy, s3_q.stamp_side);
  assign ix    = ixw[IW-1:0];
  assign iy    = iyw[IW-1:0];
  assign raddr = AW'(iy) * AW'(MAX_TEMPLATE_SIDE) + AW'(ix);
  assign waddr = AW'(s3_q.texel_y) * AW'(MAX_TEMPLATE_SIDE) + AW'(s3_q.texel_x);

  assign ram_we = en4 && v3_q && (s3_q.operation == OP_LOAD)
               && ({2'b00, s3_q.texel_x} < 8'(MAX_TEMPLATE_SIDE))
               && ({2'b00, s3_q.texel_y} < 8'(MAX_TEMPLATE_SIDE));

  assign cidx_full = CIW'(s3_q.cell_y) * CIW'(CHUNK_SIDE) + CIW'(s3_q.cell_x);

  rssb_ram #(
    .WIDTH(9),
    .DEPTH(DEPTH)
  ) u_template_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i({s3_q.texel_opaque, s3_q.texel_red}),
    .re_i   (en4),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // stage 4: texel test and material select
  logic       hit;
  out_word_t  out_d;

  assign hit                 = cand4_q && ram_rdata[8];
  assign out_d.write_valid   = hit;
  assign out_d.cell_index    = hit ? cidx4_q : 12'd0;
  assign out_d.material      = !hit ? 8'd0 :
                               (ram_rdata[7:0] == RED_BACKGROUND) ? bg_q : ram_rdata[7:0];

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= in_word_i;
    if (en2) begin
      s2_q <= s1_q;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (en3) begin
      s3_q <= s2_q;
      lx_q <= lx_d;
      ly_q <= ly_d;
    end
    if (en4) begin
      cand4_q <= cand_d;
      cidx4_q <= cidx_full[11:0];
    end
    if (en_out) out_q <= out_d;
  end

  assign out_valid_o = vout_q;
  assign out_word_o  = out_q;

  a_quiet_when_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.write_valid)
      |-> (out_word_o.cell_index == 12'd0 && out_word_o.material == 8'd0))
    else $error("result without write carries nonzero fields");

  a_empty_never_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_no_write_from_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en_out && !cand4_q) |=> !out_word_o.write_valid)
    else $error("write issued for a word that failed the bounds test");

  a_no_invented_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v4_q) |=> !out_valid_o)
    else $error("result appeared with nothing in flight");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for rotated_sprite_stamp_blit_top: stamp tests against a template.
// Fills the template store, then drives directed and random load/test words under idling.
// Depends on rssb_pkg and the blitter RTL.
module tb_top;
  import rssb_pkg::*;

  localparam int CHUNK_SIDE = 64;
  localparam int MAX_SIDE   = 64;
  localparam int FILL_SIDE  = 8;
  localparam int SEG_ITEMS  = 280;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_word_t    in_word     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_word_t   out_word;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int in_idle_pct  = 25;
  int out_idle_pct = 52;

  rotated_sprite_stamp_blit_top #(
    .CHUNK_SIDE       (CHUNK_SIDE),
    .MAX_TEMPLATE_SIDE(MAX_SIDE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  class stamp_scoreboard;
    logic [8:0]  texels [MAX_SIDE*MAX_SIDE];
    logic [17:0] origin_x;
    logic [17:0] origin_y;
    logic [7:0]  background;
    out_word_t   cell_writes [$];
    int errors;
    int loads;
    int tests;
    int writes;

    function new();
      origin_x   = '0;
      origin_y   = '0;
      background = '0;
      errors     = 0;
      loads      = 0;
      tests      = 0;
      writes     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_ORIGIN_X:   origin_x = value[17:0];
        REG_ORIGIN_Y:   origin_y = value[17:0];
        REG_BACKGROUND: background = value[7:0];
        default: ;
      endcase
    endfunction

    function int to_texel(longint v, longint side);
      longint i;
      i = (v < 0) ? 0 : (v >>> 8);
      if (i > side - 1) i = side - 1;
      return int'(i);
    endfunction

    // true when a test word reaches the store; idx is the texel it reads
    function bit locate(in_word_t w, output int idx);
      longint    side, dx, dy, half, lx, ly, top, sx, sy;
      rot_e      rot;
      idx = 0;
      side = longint'(w.stamp_side);
      if (side == 0 || side > MAX_SIDE) return 1'b0;
      dx = (longint'($signed(origin_x))*CHUNK_SIDE + longint'(w.cell_x))*256
           - longint'($signed(w.stamp_center_x));
      dy = (longint'($signed(origin_y))*CHUNK_SIDE + longint'(w.cell_y))*256
           - longint'($signed(w.stamp_center_y));
      half = side*128;
      if ((dx < 0 ? -dx : dx) >= half || (dy < 0 ? -dy : dy) >= half) return 1'b0;
      lx  = dx + half;
      ly  = dy + half;
      top = side*256 - 256;
      rot = (w.rotation >= 8'd3) ? ROT_270 : rot_e'(w.rotation[1:0]);
      case (rot)
        ROT_0: begin
          sx = lx;
          sy = ly;
        end
        ROT_90: begin
          sx = ly;
          sy = top - lx;
        end
        ROT_180: begin
          sx = top - lx;
          sy = top - ly;
        end
        default: begin
          sx = top - ly;
          sy = lx;
        end
      endcase
      idx = to_texel(sy, side)*MAX_SIDE + to_texel(sx, side);
      return 1'b1;
    endfunction

    function bit reads_unloaded(in_word_t w);
      int idx;
      if (w.operation == OP_LOAD) return 1'b0;
      if (!locate(w, idx)) return 1'b0;
      return $isunknown(texels[idx]);
    endfunction

    function out_word_t stamp_cell(in_word_t w);
      out_word_t  res;
      logic [8:0] tex;
      int         idx;
      res = '0;
      if (w.operation == OP_LOAD) begin
        texels[int'(w.texel_y)*MAX_SIDE + int'(w.texel_x)] = {w.texel_opaque, w.texel_red};
        return res;
      end
      if (!locate(w, idx)) return res;
      tex = texels[idx];
      if (!tex[8]) return res;
      res.write_valid = 1'b1;
      res.cell_index  = 12'(int'(w.cell_y)*CHUNK_SIDE + int'(w.cell_x));
      res.material    = (tex[7:0] == RED_BACKGROUND) ? background : tex[7:0];
      return res;
    endfunction

    function void note_input(in_word_t w);
      if (w.operation == OP_LOAD) loads++;
      else tests++;
      cell_writes.push_back(stamp_cell(w));
    endfunction

    function void check_result(out_word_t r);
      out_word_t e;
      if (cell_writes.size() == 0) begin
        $error("unexpected result word %0h", r);
        errors++;
        return;
      end
      e = cell_writes.pop_front();
      if (r.write_valid) writes++;
      if (r.write_valid !== e.write_valid) begin
        $error("write_valid: expected %0h, got %0h", e.write_valid, r.write_valid);
        errors++;
      end
      if (r.cell_index !== e.cell_index) begin
        $error("cell_index: expected %0h, got %0h", e.cell_index, r.cell_index);
        errors++;
      end
      if (r.material !== e.material) begin
        $error("material: expected %0h, got %0h", e.material, r.material);
        errors++;
      end
    endfunction
  endclass

  stamp_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_word);
  end

  function automatic in_word_t random_bits();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t load_word(int tx, int ty, logic opaque, logic [7:0] red);
    in_word_t w;
    w              = random_bits();
    w.operation    = OP_LOAD;
    w.texel_x      = 6'(tx);
    w.texel_y      = 6'(ty);
    w.texel_opaque = opaque;
    w.texel_red    = red;
    return w;
  endfunction

  function automatic in_word_t test_word(logic [31:0] cx, logic [31:0] cy, int side,
                                         int rot, int cellx, int celly);
    in_word_t w;
    w                = random_bits();
    w.operation      = OP_TEST;
    w.stamp_center_x = cx;
    w.stamp_center_y = cy;
    w.stamp_side     = 7'(side);
    w.rotation       = 8'(rot);
    w.cell_x         = 6'(cellx);
    w.cell_y         = 6'(celly);
    return w;
  endfunction

  function automatic in_word_t draw_item();
    in_word_t w;
    longint   half, wx, wy, cx, cy;
    int       pick;
    w = random_bits();
    if ($urandom_range(99) < 25) begin
      w.operation = OP_LOAD;
      if ($urandom_range(9) == 0) w.texel_red = RED_BACKGROUND;
      return w;
    end
    w.operation = OP_TEST;
    pick = $urandom_range(99);
    if (pick < 60) w.stamp_side = 7'($urandom_range(8, 1));
    else if (pick < 80) w.stamp_side = 7'($urandom_range(32, 9));
    else if (pick < 90) w.stamp_side = 7'($urandom_range(MAX_SIDE, 33));
    else if (pick < 95) w.stamp_side = '0;
    else w.stamp_side = 7'($urandom_range(127, MAX_SIDE + 1));
    if ($urandom_range(99) < 60) w.rotation = 8'($urandom_range(3));
    if ($urandom_range(99) < 85) begin
      half = longint'(w.stamp_side)*128;
      wx = (longint'($signed(sb.origin_x))*CHUNK_SIDE + longint'(w.cell_x))*256;
      wy = (longint'($signed(sb.origin_y))*CHUNK_SIDE + longint'(w.cell_y))*256;
      cx = wx - (longint'($urandom_range(int'(2*half + 600))) - (half + 300));
      cy = wy - (longint'($urandom_range(int'(2*half + 600))) - (half + 300));
      w.stamp_center_x = cx[31:0];
      w.stamp_center_y = cy[31:0];
    end
    return w;
  endfunction

  // redraw until the word reads only loaded texels; a small stamp always does
  function automatic in_word_t random_item();
    in_word_t w;
    w = draw_item();
    for (int n = 0; n < 200 && sb.reads_unloaded(w); n++) w = draw_item();
    if (sb.reads_unloaded(w)) w.stamp_side = 7'($urandom_range(FILL_SIDE, 1));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(w);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (sb.cell_writes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    sb.set_reg(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y: mask = 32'h3FFFF;
      REG_BACKGROUND: mask = 32'hFF;
      default: mask = '0;
    endcase
    if ((readback & mask) !== (value & mask)) begin
      $error("register %0d: expected %0h, got %0h", idx, value & mask, readback & mask);
      sb.errors++;
    end
  endtask

  task automatic set_chunk(input int ox, input int oy, input logic [7:0] bg);
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_BACKGROUND, {24'h0, bg});
  endtask

  initial begin
    int rots [6];
    rots = '{0, 1, 2, 3, 4, 255};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_chunk(0, 0, 8'h3C);

    // fill the four corner blocks of the template
    for (int ty = 0; ty < MAX_SIDE; ty++) begin
      for (int tx = 0; tx < MAX_SIDE; tx++) begin
        if ((tx < FILL_SIDE || tx >= MAX_SIDE - FILL_SIDE)
            && (ty < FILL_SIDE || ty >= MAX_SIDE - FILL_SIDE)) begin
          send_word(load_word(tx, ty, $urandom_range(99) < 70,
                              ($urandom_range(9) == 0) ? RED_BACKGROUND : 8'($urandom)));
        end
      end
    end

    send_word(load_word(0, 0, 1'b1, RED_BACKGROUND));
    send_word(load_word(MAX_SIDE-1, MAX_SIDE-1, 1'b1, 8'h00));
    send_word(load_word(MAX_SIDE-1, 0, 1'b0, 8'hAA));
    send_word(load_word(0, MAX_SIDE-1, 1'b1, 8'hFE));
    send_word(test_word(32'd0, 32'd0, 1, 0, 0, 0));
    send_word(test_word(32'd0, 32'd0, 0, 0, 0, 0));
    send_word(test_word(32'd0, 32'd0, MAX_SIDE + 1, 0, 0, 0));
    send_word(test_word(32'd0, 32'd0, 127, 0, 0, 0));
    foreach (rots[i]) begin
      send_word(test_word(32'd8191, 32'd8191, MAX_SIDE, rots[i], 0, 0));
      send_word(test_word(32'd8191, 32'd8191, MAX_SIDE, rots[i], 63, 0));
    end
    send_word(test_word(32'd8192, 32'd8192, MAX_SIDE, 0, 0, 0));
    send_word(test_word(32'h8000_0000, 32'h7FFF_FFFF, MAX_SIDE, 1, 63, 63));
    send_word(test_word(32'h7FFF_FFFF, 32'h8000_0000, MAX_SIDE, 2, 0, 63));

    for (int seg = 0; seg < 4; seg++) begin
      drain_pipeline();
      case (seg)
        0: set_chunk(3, -2, 8'h00);
        1: begin
          set_chunk(-131072, 131071, 8'hFF);
          in_idle_pct  = 52;
          out_idle_pct = 25;
        end
        2: begin
          set_chunk(131071, -131072, 8'h80);
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
        default: begin
          set_chunk($urandom_range(1) ? int'($urandom_range(64)) - 32 : int'($urandom),
                    $urandom_range(1) ? int'($urandom_range(64)) - 32 : int'($urandom),
                    8'($urandom));
          write_reg(REG_UNUSED, $urandom);
        end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) send_word(random_item());
    end

    drain_pipeline();
    $display("run covered %0d texel loads and %0d cell tests (%0d cell writes)",
             sb.loads, sb.tests, sb.writes);
    $display("across five register settings and three idling profiles");
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
